@@ rtl/smt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Set membership table package
// Shared constants, codes and types for the set membership table and its
// storage cells.
// ----------------------------------------------------------------------------
package smt_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int OPCODE_W     = 2;
    localparam int VALUE_PORT_W = 32;
    localparam int COUNT_PORT_W = 7;
    localparam int STATUS_W     = 2;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_NOCHANGE = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CMP   = 2'd1,
        S_APPLY = 2'd2
    } t_state;

    typedef struct packed {
        logic valid;
        logic cmp;
        logic ins;
        logic shift;
    } t_cell_ctrl;

endpackage
`default_nettype wire

@@ rtl/smt_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Set membership table storage cell
// Holds one element, compares it against the search key and either loads the
// key or takes the element of its right neighbor when the store closes up.
// ----------------------------------------------------------------------------
module smt_cell #(
    parameter int KEY_W = 32
) (
    input  wire                    i_clk,
    input  wire smt_pkg::t_cell_ctrl i_ctrl,
    input  wire [KEY_W-1:0]        i_key,
    input  wire [KEY_W-1:0]        i_right,
    output logic [KEY_W-1:0]       o_data,
    output logic                   o_hit
);

    logic [KEY_W-1:0] r_data;
    logic             r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            r_hit <= i_ctrl.valid && (r_data == i_key);
        end
        if (i_ctrl.ins) begin
            r_data <= i_key;
        end else if (i_ctrl.shift) begin
            r_data <= i_right;
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule
`default_nettype wire

@@ rtl/set_membership_table.sv @@
`default_nettype none
// An accepted beat on start moves the controller to the compare state, which
// compares the key in every cell, then to the apply state, which resolves the
// hit, shifts or loads the cells, strobes the result and may accept a new beat.
// Reset clears the element count and the controller; cell contents stay as
// they are and are never read until written. The receiver cannot stall.
// ----------------------------------------------------------------------------
// Set membership table
// Fixed-capacity set of distinct values held in a row of cells, with insert,
// delete with close-up, and membership query.
// ----------------------------------------------------------------------------
module set_membership_table #(
    parameter int CAPACITY    = smt_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = smt_pkg::VALUE_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    input  wire [smt_pkg::OPCODE_W-1:0]      i_opcode,
    input  wire [smt_pkg::VALUE_PORT_W-1:0]  i_value,
    output logic                             busy,
    output logic                             o_valid,
    output logic                             o_found,
    output logic [smt_pkg::COUNT_PORT_W-1:0] o_count,
    output logic [smt_pkg::STATUS_W-1:0]     o_status
);

    localparam int KEY_W = (VALUE_WIDTH < smt_pkg::VALUE_PORT_W) ? VALUE_WIDTH
                                                                  : smt_pkg::VALUE_PORT_W;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    smt_pkg::t_state                  r_state;
    smt_pkg::t_state                  n_state;
    logic [KEY_W-1:0]                 r_key;
    logic [smt_pkg::OPCODE_W-1:0]     r_op;
    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 n_count;

    smt_pkg::t_cell_ctrl              cell_ctrl [CAPACITY];
    logic [KEY_W-1:0]                 cell_data [CAPACITY];
    logic [CAPACITY-1:0]              cell_hit;

    logic                             accept;
    logic                             found;
    logic                             full;
    logic [IDX_W-1:0]                 hit_pos;
    logic                             do_ins;
    logic                             do_del;
    smt_pkg::t_status                 status;
    logic [CNT_W+smt_pkg::COUNT_PORT_W-1:0] count_ext;

    assign busy   = (r_state == smt_pkg::S_CMP);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smt_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_value[KEY_W-1:0];
            r_op  <= i_opcode;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            smt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = smt_pkg::S_CMP;
                end
            end
            smt_pkg::S_CMP: begin
                n_state = smt_pkg::S_APPLY;
            end
            smt_pkg::S_APPLY: begin
                n_state = accept ? smt_pkg::S_CMP : smt_pkg::S_IDLE;
            end
            default: begin
                n_state = smt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (cell_hit[i]) begin
                hit_pos = hit_pos | IDX_W'(i);
            end
        end
    end

    assign found = |cell_hit;
    assign full  = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        do_ins = 1'b0;
        do_del = 1'b0;
        status = smt_pkg::ST_DONE;
        case (r_op)
            smt_pkg::OP_INSERT: begin
                if (found) begin
                    status = smt_pkg::ST_NOCHANGE;
                end else if (full) begin
                    status = smt_pkg::ST_FULL;
                end else begin
                    do_ins = (r_state == smt_pkg::S_APPLY);
                end
            end
            smt_pkg::OP_DELETE: begin
                if (!found) begin
                    status = smt_pkg::ST_NOCHANGE;
                end else begin
                    do_del = (r_state == smt_pkg::S_APPLY);
                end
            end
            default: begin
                status = smt_pkg::ST_DONE;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_ctrl[i].valid = (CNT_W'(i) < r_count);
            cell_ctrl[i].cmp   = (r_state == smt_pkg::S_CMP);
            cell_ctrl[i].ins   = do_ins && (CNT_W'(i) == r_count);
            cell_ctrl[i].shift = do_del && (IDX_W'(i) >= hit_pos)
                                 && ((CNT_W + 1)'(i + 1) < {1'b0, r_count});
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] right_data;
        if (g == CAPACITY - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_mid
            assign right_data = cell_data[g+1];
        end
        smt_cell #(
            .KEY_W (KEY_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl[g]),
            .i_key   (r_key),
            .i_right (right_data),
            .o_data  (cell_data[g]),
            .o_hit   (cell_hit[g])
        );
    end

    assign count_ext = {{smt_pkg::COUNT_PORT_W{1'b0}}, n_count};
    assign o_valid   = (r_state == smt_pkg::S_APPLY);
    assign o_found   = found;
    assign o_count   = count_ext[smt_pkg::COUNT_PORT_W-1:0];
    assign o_status  = status;

`ifndef SYNTHESIS
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("Result strobe held for two cycles.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("Accepted beat did not produce a result two cycles later.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("Element count above capacity.");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smt_pkg::S_APPLY) |-> $onehot0(cell_hit))
        else $error("Key found in more than one cell.");
`endif

endmodule
`default_nettype wire
